// ----- hdl/height_colour_ramp_assert.svh -----
// Assertion shorthands used by the ramp controller RTL.
// Both expect clk and arst_n in scope.
`ifndef HEIGHT_COLOUR_RAMP_ASSERT_SVH
`define HEIGHT_COLOUR_RAMP_ASSERT_SVH

// consequent checked in the same cycle
`define HCR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define HCR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/hcr_pkg.sv -----
`default_nettype none
package hcr_pkg;

	localparam int TableEntriesDefault = 16;
	localparam int HeightW = 24;
	localparam int RgbW = 24;
	localparam int FracW = 8;

	localparam logic [RgbW-1:0] WHITE_RGB = 24'hFFFFFF;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic STATUS_DONE    = 1'b0;
	localparam logic STATUS_DROPPED = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CMP,
		S_SHIFT,
		S_SHIFT_WR,
		S_DIV,
		S_BLEND,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_DROP,
		RES_WHITE,
		RES_PREV,
		RES_CUR,
		RES_BLEND
	} res_sel_t;

	typedef struct packed {
		logic     load_in;
		logic     rd_scan;
		logic     rd_shift;
		logic     adv_prev;
		logic     inc_idx;
		logic     dec_idx;
		logic     set_pos;
		logic     wr_new;
		logic     wr_colour;
		logic     wr_shift;
		logic     div_start;
		logic     div_step;
		logic     res_en;
		res_sel_t res_sel;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic lookup;
		logic at_end;
		logic at_pos;
		logic idx_zero;
		logic empty;
		logic full;
		logic q_lt;
		logic q_eq;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

// ----- hdl/hcr_datapath.sv -----
`default_nettype none
module hcr_datapath #(
	parameter int TableEntries = hcr_pkg::TableEntriesDefault
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd,
	input  wire logic signed [hcr_pkg::HeightW-1:0] height,
	input  wire logic [hcr_pkg::RgbW-1:0]    colour_rgb,
	input  wire hcr_pkg::dp_cmd_t            cmd_i,
	output hcr_pkg::dp_status_t              st_o,
	output logic [hcr_pkg::RgbW-1:0]         result_rgb,
	output logic                             status
);
	import hcr_pkg::*;

	localparam int CW = $clog2(TableEntries + 1);
	localparam int IW = $clog2(TableEntries);

	logic [HeightW-1:0] mem_h [TableEntries];
	logic [RgbW-1:0]    mem_c [TableEntries];

	logic [CW-1:0]             cnt_q, idx_q, pos_q;
	logic [2:0]                div_cnt_q;
	logic                      cmd_q;
	logic signed [HeightW-1:0] q_h_q, rd_h_q, prev_h_q;
	logic [RgbW-1:0]           q_rgb_q, rd_c_q, prev_c_q;
	logic [HeightW-1:0]        rem_q, den_q;
	logic [FracW-1:0]          frac_q;
	logic [RgbW-1:0]           res_rgb_q, out_rgb_q;
	logic                      res_status_q, out_status_q;

	logic [IW-1:0]      wr_addr, rd_addr;
	logic               rd_en, h_we, c_we;
	logic [HeightW-1:0] h_wdata;
	logic [RgbW-1:0]    c_wdata;
	logic [HeightW:0]   rem2;
	logic               ge;
	logic [RgbW-1:0]    blend_rgb;
	logic [RgbW-1:0]    res_rgb_d;
	logic               res_status_d;

	function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] f);
		logic [8:0]  g;
		logic [17:0] acc;
		g   = 9'd256 - {1'b0, f};
		acc = ({10'd0, a} * {9'd0, g}) + ({10'd0, b} * {10'd0, f}) + 18'd128;
		return acc[15:8];
	endfunction

	assign wr_addr = idx_q[IW-1:0];
	assign rd_addr = cmd_i.rd_shift ? IW'(idx_q - CW'(1)) : idx_q[IW-1:0];
	assign rd_en   = cmd_i.rd_scan | cmd_i.rd_shift;
	assign h_we    = cmd_i.wr_new | cmd_i.wr_shift;
	assign c_we    = cmd_i.wr_new | cmd_i.wr_shift | cmd_i.wr_colour;
	assign h_wdata = cmd_i.wr_shift ? rd_h_q : q_h_q;
	assign c_wdata = cmd_i.wr_shift ? rd_c_q : q_rgb_q;

	always_ff @(posedge clk) begin
		if (h_we) begin
			mem_h[wr_addr] <= h_wdata;
		end
		if (c_we) begin
			mem_c[wr_addr] <= c_wdata;
		end
		if (rd_en) begin
			rd_h_q <= mem_h[rd_addr];
			rd_c_q <= mem_c[rd_addr];
		end
	end

	// restoring divide, one quotient bit per cycle
	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= {1'b0, den_q};

	assign blend_rgb = {mix(prev_c_q[23:16], rd_c_q[23:16], frac_q),
		mix(prev_c_q[15:8], rd_c_q[15:8], frac_q),
		mix(prev_c_q[7:0], rd_c_q[7:0], frac_q)};

	always_comb begin
		res_rgb_d    = '0;
		res_status_d = STATUS_DONE;
		unique case (cmd_i.res_sel)
			RES_ZERO: begin
				res_rgb_d = '0;
			end
			RES_DROP: begin
				res_status_d = STATUS_DROPPED;
			end
			RES_WHITE: begin
				res_rgb_d = WHITE_RGB;
			end
			RES_PREV: begin
				res_rgb_d = prev_c_q;
			end
			RES_CUR: begin
				res_rgb_d = rd_c_q;
			end
			RES_BLEND: begin
				res_rgb_d = blend_rgb;
			end
			default: begin
				res_rgb_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			div_cnt_q <= '0;
		end else begin
			if (cmd_i.wr_new) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd_i.div_start) begin
				div_cnt_q <= '0;
			end else if (cmd_i.div_step) begin
				div_cnt_q <= div_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load_in) begin
			cmd_q   <= cmd;
			q_h_q   <= height;
			q_rgb_q <= colour_rgb;
			idx_q   <= '0;
		end else if (cmd_i.set_pos) begin
			pos_q <= idx_q;
			idx_q <= cnt_q;
		end else if (cmd_i.inc_idx) begin
			idx_q <= idx_q + CW'(1);
		end else if (cmd_i.dec_idx) begin
			idx_q <= idx_q - CW'(1);
		end
		if (cmd_i.adv_prev) begin
			prev_h_q <= rd_h_q;
			prev_c_q <= rd_c_q;
		end
		if (cmd_i.div_start) begin
			rem_q <= q_h_q - prev_h_q;
			den_q <= rd_h_q - prev_h_q;
		end else if (cmd_i.div_step) begin
			rem_q  <= ge ? HeightW'(rem2 - {1'b0, den_q}) : rem2[HeightW-1:0];
			frac_q <= {frac_q[FracW-2:0], ge};
		end
		if (cmd_i.res_en) begin
			res_rgb_q    <= res_rgb_d;
			res_status_q <= res_status_d;
		end
		if (cmd_i.load_out) begin
			out_rgb_q    <= res_rgb_q;
			out_status_q <= res_status_q;
		end
	end

	assign st_o.lookup   = cmd_q == CMD_LOOKUP;
	assign st_o.at_end   = idx_q == cnt_q;
	assign st_o.at_pos   = idx_q == pos_q;
	assign st_o.idx_zero = idx_q == '0;
	assign st_o.empty    = cnt_q == '0;
	assign st_o.full     = cnt_q == CW'(TableEntries);
	assign st_o.q_lt     = q_h_q < rd_h_q;
	assign st_o.q_eq     = q_h_q == rd_h_q;
	assign st_o.div_last = div_cnt_q == 3'd7;

	assign result_rgb = out_rgb_q;
	assign status     = out_status_q;

endmodule
`default_nettype wire

// ----- hdl/hcr_ctrl.sv -----
`default_nettype none
`include "height_colour_ramp_assert.svh"
module hcr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire hcr_pkg::dp_status_t  st_i,
	output hcr_pkg::dp_cmd_t          cmd_o
);
	import hcr_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_o.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd_o    = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_o.load_in = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_SCAN: begin
				if (st_i.at_end) begin
					cmd_o.res_en = 1'b1;
					if (st_i.lookup) begin
						cmd_o.res_sel = st_i.empty ? RES_WHITE : RES_PREV;
					end else if (st_i.full) begin
						cmd_o.res_sel = RES_DROP;
					end else begin
						cmd_o.wr_new  = 1'b1;
						cmd_o.res_sel = RES_ZERO;
					end
					state_d = S_DONE;
				end else begin
					cmd_o.rd_scan = 1'b1;
					state_d       = S_CMP;
				end
			end
			S_CMP: begin
				priority if (st_i.q_eq) begin
					cmd_o.res_en = 1'b1;
					if (st_i.lookup) begin
						cmd_o.res_sel = RES_CUR;
					end else begin
						cmd_o.wr_colour = 1'b1;
						cmd_o.res_sel   = RES_ZERO;
					end
					state_d = S_DONE;
				end else if (st_i.q_lt) begin
					if (st_i.lookup) begin
						if (st_i.idx_zero) begin
							cmd_o.res_en  = 1'b1;
							cmd_o.res_sel = RES_CUR;
							state_d       = S_DONE;
						end else begin
							cmd_o.div_start = 1'b1;
							state_d         = S_DIV;
						end
					end else if (st_i.full) begin
						cmd_o.res_en  = 1'b1;
						cmd_o.res_sel = RES_DROP;
						state_d       = S_DONE;
					end else begin
						cmd_o.set_pos = 1'b1;
						state_d       = S_SHIFT;
					end
				end else begin
					cmd_o.adv_prev = 1'b1;
					cmd_o.inc_idx  = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SHIFT: begin
				if (st_i.at_pos) begin
					cmd_o.wr_new  = 1'b1;
					cmd_o.res_en  = 1'b1;
					cmd_o.res_sel = RES_ZERO;
					state_d       = S_DONE;
				end else begin
					cmd_o.rd_shift = 1'b1;
					state_d        = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				cmd_o.wr_shift = 1'b1;
				cmd_o.dec_idx  = 1'b1;
				state_d        = S_SHIFT;
			end
			S_DIV: begin
				cmd_o.div_step = 1'b1;
				if (st_i.div_last) begin
					state_d = S_BLEND;
				end
			end
			S_BLEND: begin
				cmd_o.res_en  = 1'b1;
				cmd_o.res_sel = RES_BLEND;
				state_d       = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd_o.load_out = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`HCR_ASSERT_SAME(a_no_new_in_full, cmd_o.wr_new, !st_i.full, "new point written into full table")
	`HCR_ASSERT_SAME(a_out_not_clobbered, cmd_o.load_out, !out_valid_q || out_ready, "untaken word overwritten")
	`HCR_ASSERT_NEXT(a_div_then_blend, state_q == S_DIV && st_i.div_last, state_q == S_BLEND, "divider did not hand off to blend")

endmodule
`default_nettype wire

// ----- hdl/height_colour_ramp.sv -----
// From input accept to output: a scan that reads the table entries in order, an end
// step when the scan runs past the last point or an insert opens a slot, a move up
// for each point shifted, and for a blend a serial divide to an 8-bit fraction.
// One word in flight; the next word is accepted once the result sits in the output register.
// Reset: point count cleared, table contents undefined until written; no clearing pass.
`default_nettype none
module height_colour_ramp #(
	parameter int TABLE_ENTRIES = hcr_pkg::TableEntriesDefault
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               cmd,
	input  wire logic signed [hcr_pkg::HeightW-1:0] height,
	input  wire logic [hcr_pkg::RgbW-1:0]           colour_rgb,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [hcr_pkg::RgbW-1:0]                result_rgb,
	output logic                                    status
);
	import hcr_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_st;

	hcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st_i      (dp_st),
		.cmd_o     (dp_cmd)
	);

	hcr_datapath #(
		.TableEntries (TABLE_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.height     (height),
		.colour_rgb (colour_rgb),
		.cmd_i      (dp_cmd),
		.st_o       (dp_st),
		.result_rgb (result_rgb),
		.status     (status)
	);

endmodule
`default_nettype wire
